>>> hw/rtl/hid_keyboard_report_builder_macros.svh
// Assertion macros for the HID keyboard report builder.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH

`ifndef SYNTHESIS

// Assertion on an explicit clock and active-low reset.
`define HKRB_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("HKRB assertion failed");

// Assertion on the usual clk_i and rst_ni of the enclosing module.
`define HKRB_ASSERT(lbl, prop) `HKRB_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`else

`define HKRB_ASSERT_CR(lbl, clk, rstn, prop)
`define HKRB_ASSERT(lbl, prop)

`endif

`endif

>>> hw/rtl/hkrb_pkg.sv
// Shared types, constants and helpers for the HID keyboard report builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hkrb_pkg;

  localparam int unsigned MaxSlots = 6;

  localparam logic [7:0] ModGroupMask = 8'hF0;
  localparam logic [7:0] ModGroup     = 8'hE0;
  localparam logic [7:0] ModIndexMask = 8'h0F;

  typedef enum logic [1:0] {
    ReqPress   = 2'd0,
    ReqRelease = 2'd1,
    ReqFlush   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    StIdle,
    StRemove,
    StPlace,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_code;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       report_sent;
    logic [7:0] modifier_mask;
    logic [7:0] key_out_0;
    logic [7:0] key_out_1;
    logic [7:0] key_out_2;
    logic [7:0] key_out_3;
    logic [7:0] key_out_4;
    logic [7:0] key_out_5;
  } rsp_t;

  // Slot operation requested by the sequencer for the selected slot.
  typedef struct packed {
    logic clear;
    logic write;
  } slot_cmd_t;

  // Outcome of the shared slot comparator for the selected slot.
  typedef struct packed {
    logic match;
    logic free;
  } slot_status_t;

  function automatic logic is_modifier(input logic [7:0] k);
    return (k & ModGroupMask) == ModGroup;
  endfunction

  // Only the lower eight codes of the modifier group own a bit.
  function automatic logic [7:0] modifier_bit(input logic [7:0] k);
    logic [7:0] n;
    n = k & ModIndexMask;
    return n[3] ? 8'h00 : (8'h01 << n[2:0]);
  endfunction

endpackage

>>> hw/rtl/hid_keyboard_report_builder.sv
// Top level of the HID keyboard report builder: sequencer, slot store, result register.
// Depends on hkrb_pkg, hkrb_ctrl and hkrb_slot_store.
`timescale 1ns / 1ps

// Keeps a boot-protocol keyboard report (modifier byte and KEY_SLOTS key slots)
// and updates it one request at a time. A single slot comparator is stepped over
// the slots by the sequencer, one slot per cycle, so the time an item spends in
// the block depends on the request: a press runs a removal scan, then, for a
// key that is not a modifier, a search for the lowest free slot; a release runs
// the removal scan only, and a flush or an unused code needs no scan. The input
// stalls for that whole time. Results go to a registered output beat, so a new
// request is taken while the previous result still waits on a stalled output.
module hid_keyboard_report_builder #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hkrb_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hkrb_pkg::rsp_t out_rsp_o
);
  import hkrb_pkg::*;

  localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic                         ready;
  logic [IdxW-1:0]              idx;
  logic [7:0]                   key;
  slot_cmd_t                    cmd;
  slot_status_t                 status;
  logic [MaxSlots-1:0][7:0]     report;
  logic                         out_free;
  logic                         done;
  rsp_t                         rsp;
  logic                         out_valid_q, out_valid_d;
  rsp_t                         out_rsp_q;

  hkrb_ctrl #(
    .KEY_SLOTS (KEY_SLOTS),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .ready_o    (ready),
    .idx_o      (idx),
    .key_o      (key),
    .cmd_o      (cmd),
    .status_i   (status),
    .report_i   (report),
    .out_free_i (out_free),
    .done_o     (done),
    .rsp_o      (rsp)
  );

  hkrb_slot_store #(
    .KEY_SLOTS (KEY_SLOTS),
    .IdxW      (IdxW)
  ) u_slot_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (idx),
    .key_i    (key),
    .cmd_i    (cmd),
    .status_o (status),
    .report_o (report)
  );

  // The output register can take a new beat when empty or when its beat leaves now.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (done && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      out_rsp_q <= rsp;
    end
  end

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> hw/rtl/hkrb_slot_store.sv
// Key slot storage with the single shared slot comparator.
// Depends on hkrb_pkg for the slot command and status types.
`timescale 1ns / 1ps

module hkrb_slot_store #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned IdxW      = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [IdxW-1:0]             idx_i,
  input  logic [7:0]                  key_i,
  input  hkrb_pkg::slot_cmd_t         cmd_i,
  output hkrb_pkg::slot_status_t      status_o,
  output logic [hkrb_pkg::MaxSlots-1:0][7:0] report_o
);
  import hkrb_pkg::*;

  logic [7:0]           keys_q [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] used_q;
  logic [KEY_SLOTS-1:0] used_d;

  always_comb begin
    used_d = used_q;
    if (cmd_i.clear) begin
      used_d[idx_i] = 1'b0;
    end else if (cmd_i.write) begin
      used_d[idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Freed slots keep their old byte; the report masks them with the used marks.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      keys_q[idx_i] <= key_i;
    end
  end

  assign status_o.match = used_q[idx_i] && (keys_q[idx_i] == key_i);
  assign status_o.free  = !used_q[idx_i];

  for (genvar j = 0; j < MaxSlots; j++) begin : g_report
    if (j < KEY_SLOTS) begin : g_live
      assign report_o[j] = used_q[j] ? keys_q[j] : 8'h00;
    end else begin : g_absent
      assign report_o[j] = 8'h00;
    end
  end

endmodule

>>> hw/rtl/hkrb_ctrl.sv
// Sequencer of the report builder: removal scan, placement scan and result.
// Depends on hkrb_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "hid_keyboard_report_builder_macros.svh"

module hkrb_ctrl #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned IdxW      = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  hkrb_pkg::req_t              in_req_i,
  output logic                        ready_o,
  output logic [IdxW-1:0]             idx_o,
  output logic [7:0]                  key_o,
  output hkrb_pkg::slot_cmd_t         cmd_o,
  input  hkrb_pkg::slot_status_t      status_i,
  input  logic [hkrb_pkg::MaxSlots-1:0][7:0] report_i,
  input  logic                        out_free_i,
  output logic                        done_o,
  output hkrb_pkg::rsp_t              rsp_o
);
  import hkrb_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(KEY_SLOTS - 1);

  ctrl_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [1:0]      type_q, type_d;
  logic [7:0]      key_q, key_d;
  logic            acc_q, acc_d;
  logic [7:0]      mod_q, mod_d;
  logic            pend_q, pend_d;
  logic            sent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      mod_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      mod_q   <= mod_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    key_q  <= key_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    type_d  = type_q;
    key_d   = key_q;
    acc_d   = acc_q;
    mod_d   = mod_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    ready_o = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        ready_o = 1'b1;
        if (in_valid_i) begin
          type_d = in_req_i.req_type;
          key_d  = in_req_i.key_code;
          idx_d  = '0;
          acc_d  = 1'b0;
          if (in_req_i.req_type inside {ReqPress, ReqRelease}) begin
            state_d = StRemove;
          end else begin
            state_d = StDone;
          end
        end
      end
      StRemove: begin
        if (status_i.match) begin
          cmd_o.clear = 1'b1;
          pend_d      = 1'b1;
        end
        if (status_i.match || idx_q == LastIdx) begin
          // A press of a modifier sets its bit and a release clears it; modifiers take no key slot.
          if (is_modifier(key_q)) begin
            pend_d = 1'b1;
            if (type_q == ReqPress) begin
              mod_d = mod_q | modifier_bit(key_q);
            end else begin
              mod_d = mod_q & ~modifier_bit(key_q);
            end
          end
          if (type_q == ReqRelease) begin
            acc_d   = status_i.match;
            state_d = StDone;
          end else if (is_modifier(key_q)) begin
            acc_d   = 1'b1;
            state_d = StDone;
          end else begin
            idx_d   = '0;
            state_d = StPlace;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StPlace: begin
        if (status_i.free) begin
          cmd_o.write = 1'b1;
          pend_d      = 1'b1;
          acc_d       = 1'b1;
          state_d     = StDone;
        end else if (idx_q == LastIdx) begin
          acc_d   = 1'b0;
          state_d = StDone;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDone: begin
        done_o = 1'b1;
        if (out_free_i) begin
          if (sent) begin
            pend_d = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign idx_o = idx_q;
  assign key_o = key_q;

  assign sent = (type_q == ReqFlush) && pend_q;

  assign rsp_o.accepted      = acc_q;
  assign rsp_o.report_sent   = sent;
  assign rsp_o.modifier_mask = sent ? mod_q : 8'h00;
  assign rsp_o.key_out_0     = sent ? report_i[0] : 8'h00;
  assign rsp_o.key_out_1     = sent ? report_i[1] : 8'h00;
  assign rsp_o.key_out_2     = sent ? report_i[2] : 8'h00;
  assign rsp_o.key_out_3     = sent ? report_i[3] : 8'h00;
  assign rsp_o.key_out_4     = sent ? report_i[4] : 8'h00;
  assign rsp_o.key_out_5     = sent ? report_i[5] : 8'h00;

  `HKRB_ASSERT(a_write_only_free, cmd_o.write |-> (status_i.free && state_q == StPlace))
  `HKRB_ASSERT(a_idx_in_range, (state_q == StRemove || state_q == StPlace) |-> idx_q <= LastIdx)
  `HKRB_ASSERT(a_flush_clears, (done_o && out_free_i && sent) |=> !pend_q)

endmodule
